>>> rtl/slid_pkg.sv
// Shared types, codes and constants for the sorted list insert/delete unit.
package slid_pkg;

    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 10;
    localparam int FILL_W        = 11;
    localparam int DEPTH_DEFAULT = 1024;
    localparam int QUEUE_DEPTH   = 2;

    // Operation codes on the item channel
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Status codes on the result channel
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [FILL_W-1:0]         fill;
        logic signed [VALUE_W-1:0] read_value;
        logic                      error_seen;
    } result_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DELETE,
        ST_READ
    } back_state_t;

endpackage

>>> rtl/sorted_list_insert_delete_unit.sv
// Sorted list unit: ascending table of signed words with insert, delete-at and read-at.
//
// Item channel: drive item and raise start; the item transfers at a rising edge
// where start is high and busy is low. kind selects insert, delete at rank or
// read at rank; any other code is a no-op that still gets a result.
// Result channel: done is high for exactly one cycle per item, in item order,
// with status, fill, read_value and error_seen on result. The receiver must
// take it in that cycle; it cannot hold results off.
// A no-op, a refused item, an insert into an empty table and a delete of the
// last entry are finished by the back end as it takes the command; a read waits
// for the registered RAM data; an insert into a nonempty table moves its larger
// entries up one at a time, and a delete moves the entries behind the rank down.
// The table RAM moves one entry per cycle through its single read and single
// write port, and the back end takes no new command until the current one is done.
// A two-entry command queue lets the front end keep taking items meanwhile;
// busy rises only when the queue and the front stage are both full.
// Reset empties the table (fill 0) and clears the sticky delete error.
module sorted_list_insert_delete_unit #(
    parameter int DEPTH = slid_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slid_pkg::item_t   item,
    output logic              done,
    output slid_pkg::result_t result
);

    slid_pkg::queue_push_t push;
    slid_pkg::queue_head_t head;
    logic                  queue_full;
    logic                  pop;

    slid_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .push       (push),
        .queue_full (queue_full)
    );

    slid_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    slid_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

    // A full-table refusal only happens with the table at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == slid_pkg::STATUS_FULL)
        |-> (result.fill == slid_pkg::FILL_W'(DEPTH)))
    else $error("full status with table below capacity");

    // A refused item never returns data
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != slid_pkg::STATUS_OK) |-> (result.read_value == '0))
    else $error("refused item returned nonzero data");

    // Fill never exceeds the table capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.fill <= slid_pkg::FILL_W'(DEPTH)))
    else $error("fill beyond capacity");

    // No result appears while the command path is empty and the back end idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(head.valid) && !$past(done) && $past(rst_n)
        && (u_back.state_reg == slid_pkg::ST_IDLE)
        && ($past(u_back.state_reg) == slid_pkg::ST_IDLE) |-> !done)
    else $error("result without a command");

endmodule

>>> rtl/slid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/slid_front.sv
// Front end: takes items, decodes the operation and hands commands to the queue.
module slid_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  slid_pkg::item_t      item,
    output slid_pkg::queue_push_t push,
    input  logic                 queue_full
);

    logic           stage_valid_reg;
    logic           stage_valid_next;
    slid_pkg::cmd_t stage_cmd_reg;
    slid_pkg::cmd_t stage_cmd_next;
    slid_pkg::op_t  op_dec;
    logic           accept;
    logic           do_push;

    // Decode the operation code
    always_comb
    begin
        unique case (item.kind)
            slid_pkg::KIND_INSERT: op_dec = slid_pkg::OP_INSERT;
            slid_pkg::KIND_DELETE: op_dec = slid_pkg::OP_DELETE;
            slid_pkg::KIND_READ:   op_dec = slid_pkg::OP_READ;
            default:               op_dec = slid_pkg::OP_NOP;
        endcase
    end

    // Hold the stage while the queue is full, refill it on a transfer
    assign do_push = stage_valid_reg && !queue_full;
    assign busy    = stage_valid_reg && queue_full;
    assign accept  = start && !busy;

    always_comb
    begin
        stage_valid_next = accept || (stage_valid_reg && !do_push);
        stage_cmd_next   = stage_cmd_reg;
        if (accept)
        begin
            stage_cmd_next.op    = op_dec;
            stage_cmd_next.value = item.value;
            stage_cmd_next.rank  = item.rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg <= stage_cmd_next;
    end

    assign push.valid = do_push;
    assign push.cmd   = stage_cmd_reg;

endmodule

>>> rtl/slid_queue.sv
// Small command queue between the front end and the back end.
module slid_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slid_pkg::queue_push_t push,
    output logic                  full,
    output slid_pkg::queue_head_t head,
    input  logic                  pop
);

    localparam int PTR_W = (slid_pkg::QUEUE_DEPTH > 1) ? $clog2(slid_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(slid_pkg::QUEUE_DEPTH + 1);

    slid_pkg::cmd_t   slot_reg [slid_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] level_reg;
    logic [CNT_W-1:0] level_next;
    logic             do_pop;

    assign full       = (level_reg == CNT_W'(slid_pkg::QUEUE_DEPTH));
    assign head.valid = (level_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Advance pointers and level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(slid_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(slid_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            level_next = level_reg + CNT_W'(1);
        end
        else if (do_pop && !push.valid)
        begin
            level_next = level_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

>>> rtl/slid_back.sv
// Back end: carries out commands on the sorted table and issues one result each.
module slid_back #(
    parameter int DEPTH = slid_pkg::DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slid_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  done,
    output slid_pkg::result_t     result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > slid_pkg::RANK_W) ? CNT_W : slid_pkg::RANK_W;

    slid_pkg::back_state_t state_reg;
    slid_pkg::back_state_t state_next;
    slid_pkg::cmd_t        cmd_reg;
    slid_pkg::cmd_t        cmd_next;
    logic [ADDR_W-1:0]     pos_reg;
    logic [ADDR_W-1:0]     pos_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  sticky_reg;
    logic                  sticky_next;
    logic                  done_reg;
    logic                  done_next;
    slid_pkg::result_t     result_reg;
    slid_pkg::result_t     result_next;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [slid_pkg::VALUE_W-1:0]  ram_wdata;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [slid_pkg::VALUE_W-1:0]  ram_rdata;

    logic                          emit;
    logic [1:0]                    emit_status;
    logic [slid_pkg::VALUE_W-1:0]  emit_value;
    logic [ADDR_W-1:0]             last_addr;
    logic [ADDR_W-1:0]             head_rank_addr;
    logic                          head_rank_bad;
    logic                          table_full;
    logic                          move_up;

    slid_ram #(
        .WIDTH (slid_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_addr      = ADDR_W'(count_reg - CNT_W'(1));
    assign head_rank_addr = ADDR_W'(head.cmd.rank);
    assign head_rank_bad  = (CMP_W'(head.cmd.rank) >= CMP_W'(count_reg));
    assign table_full     = (count_reg == CNT_W'(DEPTH));
    assign move_up        = (pos_reg != '0) && ($signed(ram_rdata) > cmd_reg.value);

    // Sequence each command over the table
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        sticky_next = sticky_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = pos_reg;
        emit        = 1'b0;
        emit_status = slid_pkg::STATUS_OK;
        emit_value  = '0;

        unique case (state_reg)
            slid_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    unique case (head.cmd.op)
                        slid_pkg::OP_INSERT:
                        begin
                            if (table_full)
                            begin
                                emit        = 1'b1;
                                emit_status = slid_pkg::STATUS_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = head.cmd.value;
                                count_next = CNT_W'(1);
                                emit       = 1'b1;
                            end
                            else
                            begin
                                pos_next   = ADDR_W'(count_reg);
                                ram_re     = 1'b1;
                                ram_raddr  = last_addr;
                                state_next = slid_pkg::ST_INSERT;
                            end
                        end
                        slid_pkg::OP_DELETE:
                        begin
                            if (head_rank_bad)
                            begin
                                sticky_next = 1'b1;
                                emit        = 1'b1;
                                emit_status = slid_pkg::STATUS_RANGE;
                            end
                            else if (head_rank_addr == last_addr)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                emit       = 1'b1;
                            end
                            else
                            begin
                                pos_next   = head_rank_addr;
                                ram_re     = 1'b1;
                                ram_raddr  = head_rank_addr + ADDR_W'(1);
                                state_next = slid_pkg::ST_DELETE;
                            end
                        end
                        slid_pkg::OP_READ:
                        begin
                            if (head_rank_bad)
                            begin
                                emit        = 1'b1;
                                emit_status = slid_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_rank_addr;
                                state_next = slid_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            // Shift larger entries up one slot, then drop the value in
            slid_pkg::ST_INSERT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                if (move_up)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - ADDR_W'(1);
                    if (pos_reg != ADDR_W'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    ram_wdata  = cmd_reg.value;
                    count_next = count_reg + CNT_W'(1);
                    emit       = 1'b1;
                    state_next = slid_pkg::ST_IDLE;
                end
            end

            // Shift later entries down one slot over the removed one
            slid_pkg::ST_DELETE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
                pos_next  = pos_reg + ADDR_W'(1);
                if (pos_reg + ADDR_W'(1) == last_addr)
                begin
                    count_next = count_reg - CNT_W'(1);
                    emit       = 1'b1;
                    state_next = slid_pkg::ST_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg + ADDR_W'(2);
                end
            end

            slid_pkg::ST_READ:
            begin
                emit       = 1'b1;
                emit_value = ram_rdata;
                state_next = slid_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = slid_pkg::ST_IDLE;
            end
        endcase

        done_next              = emit;
        result_next            = result_reg;
        if (emit)
        begin
            result_next.status     = emit_status;
            result_next.fill       = slid_pkg::FILL_W'(count_next);
            result_next.read_value = emit_value;
            result_next.error_seen = sticky_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= slid_pkg::ST_IDLE;
            count_reg  <= '0;
            sticky_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sticky_reg <= sticky_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
